// ----- src/afk_pkg.sv -----
// Shared types, constants and arithmetic helpers for the arm forward kinematics block.
package afk_pkg;

    // Internal fixed point: signed Q30
    localparam int FRAC  = 30;
    localparam int Q_W   = 32;
    localparam int Z_W   = 35;
    localparam int LIM_W = 34;
    localparam int ATAN_LEN = 24;
    localparam int JOINTS   = 6;

    // Defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int POSITION_BITS_DEF = 20;
    localparam int CORDIC_STEPS_DEF  = 16;

    // Configuration port
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HEIGHT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 4'd1;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic signed [2*Q_W-1:0] prod_t;

    // Pose after a joint: rotation, origin and running clearance flag
    typedef struct packed {
        q_t [2:0][2:0] rot;
        q_t [2:0]      pos;
        logic          clear;
    } pose_t;

    // What a CORDIC lane hands to its transform stage
    typedef struct packed {
        q_t cos_v;
        q_t sin_v;
        q_t tx;
        q_t ty;
    } lane_t;

    localparam q_t ONE_Q = 32'sd1073741824;
    localparam q_t GAIN_Q = 32'sd652032874;
    localparam logic signed [Z_W-1:0] PI_Z      = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Z = 35'sd1686629713;

    localparam q_t ATAN_Q [ATAN_LEN] = '{
        32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
        32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
        32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
        32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
        32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
        32'sd1024,      32'sd512,       32'sd256,       32'sd128
    };

    // Link table: length a, offset d, twist (+1 quarter turn, -1, or none)
    localparam q_t LINK_A [JOINTS] = '{
        32'sd0, -32'sd456340275, -32'sd421175230, 32'sd0, 32'sd0, 32'sd0
    };
    localparam q_t LINK_D [JOINTS] = '{
        32'sd95733747, 32'sd0, 32'sd0, 32'sd117198920, 32'sd101629664, 32'sd88368952
    };
    localparam logic signed [1:0] LINK_TWIST [JOINTS] = '{
        2'sd1, 2'sd0, 2'sd0, 2'sd1, -2'sd1, 2'sd0
    };

    // Q30 product rounded back to Q30
    function automatic q_t mul_round(prod_t p);
        prod_t t;
        prod_t s;
        t = p + (prod_t'(1) <<< (FRAC - 1));
        s = t >>> FRAC;
        return q_t'(s[Q_W-1:0]);
    endfunction

    // Sum of four Q30 terms, added without loss in a wider accumulator, then truncated to Q_W bits
    function automatic q_t sum4(q_t a, q_t b, q_t c, q_t d);
        logic signed [Q_W+1:0] acc;
        acc = {{2{a[Q_W-1]}}, a} + {{2{b[Q_W-1]}}, b}
            + {{2{c[Q_W-1]}}, c} + {{2{d[Q_W-1]}}, d};
        return q_t'(acc[Q_W-1:0]);
    endfunction

    // Q30 to position format: round half up, then saturate
    function automatic logic signed [LIM_W-1:0] to_pos(q_t v, int pbits);
        logic signed [LIM_W-1:0] w;
        logic signed [LIM_W-1:0] r;
        logic signed [LIM_W-1:0] hi;
        logic signed [LIM_W-1:0] lo;
        int s;
        s  = FRAC - (pbits - 4);
        w  = {{(LIM_W-Q_W){v[Q_W-1]}}, v};
        w  = w + (LIM_W'(1) <<< (s - 1));
        r  = w >>> s;
        hi = (LIM_W'(1) <<< (pbits - 1)) - LIM_W'(1);
        lo = -hi - LIM_W'(1);
        if (r > hi)
        begin
            r = hi;
        end
        else if (r < lo)
        begin
            r = lo;
        end
        return r;
    endfunction

endpackage

// ----- src/afk_cordic_lane.sv -----
// One joint lane: input delay, pipelined CORDIC sine/cosine, link translation products.
module afk_cordic_lane
    import afk_pkg::*;
#(
    parameter int J            = 0,
    parameter int LEAD         = 0,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output lane_t                 lane_out
);

    localparam int SH = FRAC - (ANGLE_BITS - 3);

    logic [ANGLE_BITS-1:0]   ang;
    logic signed [Z_W-1:0]   z_wide;

    // Delay so this lane lines up with its place in the transform chain
    generate
        if (LEAD > 0)
        begin : g_lead
            logic [ANGLE_BITS-1:0] dly_reg [LEAD];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dly_reg[0] <= angle;
                    for (int k = 1; k < LEAD; k++)
                    begin
                        dly_reg[k] <= dly_reg[k-1];
                    end
                end
            end
            assign ang = dly_reg[LEAD-1];
        end
        else
        begin : g_nolead
            assign ang = angle;
        end
    endgenerate

    assign z_wide = $signed({{(Z_W-ANGLE_BITS){ang[ANGLE_BITS-1]}}, ang}) <<< SH;

    q_t                    x_reg [CORDIC_STEPS+1];
    q_t                    y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0] z_reg [CORDIC_STEPS+1];
    logic                  neg_reg [CORDIC_STEPS+1];

    // Fold into [-pi/2, pi/2]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_Q;
            y_reg[0] <= '0;
            if (z_wide > HALF_PI_Z)
            begin
                z_reg[0]   <= z_wide - PI_Z;
                neg_reg[0] <= 1'b1;
            end
            else if (z_wide < -HALF_PI_Z)
            begin
                z_reg[0]   <= z_wide + PI_Z;
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]   <= z_wide;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    // One rotation step per stage
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [Z_W-1:0] atan_z;
            assign atan_z = {{(Z_W-Q_W){ATAN_Q[i][Q_W-1]}}, ATAN_Q[i]};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg[i+1] <= neg_reg[i];
                    if (!z_reg[i][Z_W-1])
                    begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - atan_z;
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + atan_z;
                    end
                end
            end
        end
    endgenerate

    // Undo the fold, form link length times cos and sin
    q_t    cos_c;
    q_t    sin_c;
    q_t    cos_reg;
    q_t    sin_reg;
    prod_t px_reg;
    prod_t py_reg;

    assign cos_c = neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign sin_c = neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_c;
            sin_reg <= sin_c;
            px_reg  <= LINK_A[J] * cos_c;
            py_reg  <= LINK_A[J] * sin_c;
        end
    end

    // Round translation terms
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_out.cos_v <= cos_reg;
            lane_out.sin_v <= sin_reg;
            lane_out.tx    <= mul_round(px_reg);
            lane_out.ty    <= mul_round(py_reg);
        end
    end

endmodule

// ----- src/afk_joint.sv -----
// One link transform: multiplies the running pose by a joint's homogeneous matrix.
module afk_joint
    import afk_pkg::*;
#(
    parameter int J             = 0,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    en,
    input  pose_t                   pose_in,
    input  lane_t                   lane_in,
    input  logic signed [LIM_W-1:0] limit,
    output pose_t                   pose_out
);

    localparam logic signed [1:0] SA = LINK_TWIST[J];

    q_t   lmat [3][3];
    q_t   tvec [3];
    logic chk;

    // Link matrix: twist is a quarter turn or none, so only selection
    always_comb
    begin
        lmat[0][0] = lane_in.cos_v;
        lmat[1][0] = lane_in.sin_v;
        lmat[2][0] = '0;
        if (SA == 2'sd1)
        begin
            lmat[0][1] = '0;
            lmat[1][1] = '0;
            lmat[2][1] = ONE_Q;
            lmat[0][2] = lane_in.sin_v;
            lmat[1][2] = -lane_in.cos_v;
            lmat[2][2] = '0;
        end
        else if (SA == -2'sd1)
        begin
            lmat[0][1] = '0;
            lmat[1][1] = '0;
            lmat[2][1] = -ONE_Q;
            lmat[0][2] = -lane_in.sin_v;
            lmat[1][2] = lane_in.cos_v;
            lmat[2][2] = '0;
        end
        else
        begin
            lmat[0][1] = -lane_in.sin_v;
            lmat[1][1] = lane_in.cos_v;
            lmat[2][1] = '0;
            lmat[0][2] = '0;
            lmat[1][2] = '0;
            lmat[2][2] = ONE_Q;
        end
        tvec[0] = lane_in.tx;
        tvec[1] = lane_in.ty;
        tvec[2] = LINK_D[J];
    end

    // Clearance of the incoming origin; frames from the second on are checked
    generate
        if (J >= 2)
        begin : g_chk
            assign chk = to_pos(pose_in.pos[2], POSITION_BITS) > limit;
        end
        else
        begin : g_nochk
            assign chk = 1'b1;
        end
    endgenerate

    prod_t rp_reg [3][3][3];
    prod_t tp_reg [3][3];
    q_t    pos_reg [3];
    logic  clear_reg;

    // Products stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rp_reg[r][k][i] <= pose_in.rot[r][i] * lmat[i][k];
                    end
                    tp_reg[r][i] <= pose_in.rot[r][i] * tvec[i];
                end
                pos_reg[r] <= pose_in.pos[r];
            end
            clear_reg <= pose_in.clear & chk;
        end
    end

    // Rounding and sums stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pose_out.rot[r][k] <= sum4(mul_round(rp_reg[r][k][0]),
                                               mul_round(rp_reg[r][k][1]),
                                               mul_round(rp_reg[r][k][2]), '0);
                end
                pose_out.pos[r] <= sum4(pos_reg[r], mul_round(tp_reg[r][0]),
                                        mul_round(tp_reg[r][1]),
                                        mul_round(tp_reg[r][2]));
            end
            pose_out.clear <= clear_reg;
        end
    end

endmodule

// ----- src/arm_forward_kinematics.sv -----
// Top level: six CORDIC lanes feeding a chain of six link transforms, output stage.
// Throughput: one pose per cycle; the whole pipeline advances together and
// holds only while a finished result is stalled at the output register.
// Reset: asynchronous, active low; clears the valid pipeline and both
// configuration registers (table height and clearance margin to zero).
module arm_forward_kinematics
    import afk_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_IDX_W-1:0]            cfg_index,
    input  logic [POSITION_BITS-1:0]        cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [ANGLE_BITS-1:0]    angle_base,
    input  logic signed [ANGLE_BITS-1:0]    angle_shoulder,
    input  logic signed [ANGLE_BITS-1:0]    angle_elbow,
    input  logic signed [ANGLE_BITS-1:0]    angle_wrist_one,
    input  logic signed [ANGLE_BITS-1:0]    angle_wrist_two,
    input  logic signed [ANGLE_BITS-1:0]    angle_wrist_three,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [POSITION_BITS-1:0] tool_x,
    output logic signed [POSITION_BITS-1:0] tool_y,
    output logic signed [POSITION_BITS-1:0] tool_z,
    output logic                            clear_of_table
);

    localparam int LAT = CORDIC_STEPS + 16;

    logic                        en;
    logic [LAT-1:0]              vld_reg;
    logic [POSITION_BITS-1:0]    height_reg;
    logic [15:0]                 margin_reg;
    logic signed [LIM_W-1:0]     limit;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= '0;
            margin_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TABLE_HEIGHT: height_reg <= cfg_data;
                CFG_MARGIN:       margin_reg <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign limit = $signed({{(LIM_W-POSITION_BITS){height_reg[POSITION_BITS-1]}}, height_reg})
                 + $signed({{(LIM_W-16){1'b0}}, margin_reg});

    // Pipeline advance and valid tracking
    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Lanes, each delayed to meet its transform stage
    logic [ANGLE_BITS-1:0] ang [JOINTS];
    lane_t                 lanes [JOINTS];
    pose_t                 poses [JOINTS+1];

    assign ang[0] = angle_base;
    assign ang[1] = angle_shoulder;
    assign ang[2] = angle_elbow;
    assign ang[3] = angle_wrist_one;
    assign ang[4] = angle_wrist_two;
    assign ang[5] = angle_wrist_three;

    // Identity pose at the base
    always_comb
    begin
        poses[0] = '0;
        poses[0].rot[0][0] = ONE_Q;
        poses[0].rot[1][1] = ONE_Q;
        poses[0].rot[2][2] = ONE_Q;
        poses[0].clear     = 1'b1;
    end

    genvar j;
    generate
        for (j = 0; j < JOINTS; j++)
        begin : g_joint
            afk_cordic_lane #(
                .J            (j),
                .LEAD         (2 * j),
                .ANGLE_BITS   (ANGLE_BITS),
                .CORDIC_STEPS (CORDIC_STEPS)
            ) u_lane (
                .clk      (clk),
                .en       (en),
                .angle    (ang[j]),
                .lane_out (lanes[j])
            );

            afk_joint #(
                .J             (j),
                .POSITION_BITS (POSITION_BITS)
            ) u_joint (
                .clk      (clk),
                .en       (en),
                .pose_in  (poses[j]),
                .lane_in  (lanes[j]),
                .limit    (limit),
                .pose_out (poses[j+1])
            );
        end
    endgenerate

    // Output stage: round and saturate the tool origin, final clearance check
    logic signed [LIM_W-1:0] px;
    logic signed [LIM_W-1:0] py;
    logic signed [LIM_W-1:0] pz;

    assign px = to_pos(poses[JOINTS].pos[0], POSITION_BITS);
    assign py = to_pos(poses[JOINTS].pos[1], POSITION_BITS);
    assign pz = to_pos(poses[JOINTS].pos[2], POSITION_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tool_x         <= px[POSITION_BITS-1:0];
            tool_y         <= py[POSITION_BITS-1:0];
            tool_z         <= pz[POSITION_BITS-1:0];
            clear_of_table <= poses[JOINTS].clear & (pz > limit);
        end
    end

    assign out_valid = vld_reg[LAT-1];

endmodule
